>>> hw/rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared constants, codes and types of the first-fit unit allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    // pool geometry
    localparam int UNIT_COUNT    = 256;
    localparam int GRANULE_SHIFT = 16;
    localparam int MAX_RUN       = 255;

    // field widths
    localparam int ADDR_W    = 48;
    localparam int BYTES_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int UNITS_W   = 9;
    localparam int LEN_W     = 8;
    localparam int ENTRY_W   = LEN_W + 1;
    localparam int IDX_W     = $clog2(UNIT_COUNT);
    localparam int CNT_W     = $clog2(UNIT_COUNT + 1);
    localparam int HINT_W    = BYTES_W + 1 - GRANULE_SHIFT;
    localparam int SUM_W     = (HINT_W > CNT_W) ? HINT_W : CNT_W;
    localparam int GOFF_W    = ADDR_W - GRANULE_SHIFT;

    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(UNIT_COUNT - 1);
    localparam logic [BYTES_W:0]   ROUND_ADD  = (BYTES_W + 1)'((64'd1 << GRANULE_SHIFT) - 64'd1);

    // configuration registers
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ADDR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REQUEST = 1'b1;
    localparam logic [BYTES_W-1:0]   MAX_REQUEST_RST = 32'd8388608;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FIT   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd3;

    // configuration seen by the controller
    typedef struct packed {
        logic [ADDR_W-1:0]  pool_base;
        logic [BYTES_W-1:0] max_request_bytes;
    } cfg_t;

    // saturate a granule count to the result field
    function automatic logic [UNITS_W-1:0] sat_units(input logic [CNT_W-1:0] units);
        logic [31:0] wide;
        wide = 32'(units);
        return (wide > 32'd511) ? 9'h1FF : wide[UNITS_W-1:0];
    endfunction

endpackage

>>> hw/rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa_if
// Item channels of the allocator: request, result and configuration write.
// ----------------------------------------------------------------------------
interface ffa_req_if import ffa_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;

    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink   (input valid, command, request_bytes, block_address, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_base;
    logic [UNITS_W-1:0]  run_units;

    modport source (output valid, status, block_base, run_units, input ready);
    modport sink   (input valid, status, block_base, run_units, output ready);
endinterface

interface ffa_cfg_if import ffa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/ffa_ram.sv
// ----------------------------------------------------------------------------
// ffa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// Allocation sequencer: table clear after reset, request checks, first-fit
// scan over the granule table, mark and release passes, result register.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    ffa_req_if.sink             req,
    ffa_rsp_if.source           rsp,
    output logic                mem_we,
    output logic [IDX_W-1:0]    mem_waddr,
    output logic [ENTRY_W-1:0]  mem_wdata,
    output logic [IDX_W-1:0]    mem_raddr,
    input  logic [ENTRY_W-1:0]  mem_rdata
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_MARK,
        S_FREE_RD,
        S_FREE_CHK,
        S_RELEASE,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [CNT_W-1:0]    units_reg, units_next;
    logic [HINT_W-1:0]   hint_reg, hint_next;
    logic [IDX_W-1:0]    unit_reg, unit_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    chk_reg, chk_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic [ADDR_W-1:0]   rsp_base_reg, rsp_base_next;
    logic [UNITS_W-1:0]  rsp_units_reg, rsp_units_next;

    logic [BYTES_W:0]    round_sum;
    logic [HINT_W-1:0]   gran_units;
    logic [BYTES_W:0]    rounded_bytes;
    logic                alloc_bad;
    logic [ADDR_W:0]     addr_diff;
    logic                free_bad;
    logic [CNT_W-1:0]    run_cnt;
    logic [CNT_W-1:0]    fit_base;
    logic                entry_used;
    logic [LEN_W-1:0]    entry_len;
    logic [SUM_W-1:0]    free_units;
    logic [SUM_W-1:0]    units_left;
    logic [CNT_W-1:0]    cnt_inc;

    // request rounding and range checks
    always_comb
    begin
        round_sum     = {1'b0, bytes_reg} + ROUND_ADD;
        gran_units    = round_sum[BYTES_W:GRANULE_SHIFT];
        rounded_bytes = {gran_units, {GRANULE_SHIFT{1'b0}}};
        alloc_bad     = (bytes_reg == '0)
                     || (bytes_reg > cfg.max_request_bytes)
                     || (rounded_bytes > {1'b0, cfg.max_request_bytes})
                     || (32'(gran_units) > 32'(UNIT_COUNT))
                     || (32'(gran_units) > 32'(MAX_RUN));
        addr_diff     = {1'b0, addr_reg} - {1'b0, cfg.pool_base};
        free_bad      = addr_diff[ADDR_W]
                     || (addr_diff[ADDR_W-1:GRANULE_SHIFT] >= GOFF_W'(UNIT_COUNT))
                     || (addr_diff[GRANULE_SHIFT-1:0] != '0);
    end

    // scan and release arithmetic
    always_comb
    begin
        entry_used = mem_rdata[ENTRY_W-1];
        entry_len  = mem_rdata[LEN_W-1:0];
        run_cnt    = entry_used ? '0 : (cnt_reg + CNT_W'(1));
        fit_base   = CNT_W'(chk_reg) + CNT_W'(1) - units_reg;
        if (entry_len != '0)
        begin
            free_units = SUM_W'(entry_len);
        end
        else if (hint_reg == '0)
        begin
            free_units = SUM_W'(1);
        end
        else
        begin
            free_units = SUM_W'(hint_reg);
        end
        units_left = SUM_W'(UNIT_COUNT) - SUM_W'(unit_reg);
        cnt_inc    = cnt_reg + CNT_W'(1);
    end

    // memory port drive
    always_comb
    begin
        mem_raddr = ptr_reg;
        mem_waddr = ptr_reg;
        mem_we    = 1'b0;
        mem_wdata = '0;
        case (state_reg) inside
            S_CLEAR, S_RELEASE:
            begin
                mem_we = 1'b1;
            end
            S_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = {1'b1, (ptr_reg == unit_reg) ? LEN_W'(units_reg) : LEN_W'(0)};
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        bytes_next      = bytes_reg;
        addr_next       = addr_reg;
        units_next      = units_reg;
        hint_next       = hint_reg;
        unit_next       = unit_reg;
        ptr_next        = ptr_reg;
        chk_next        = chk_reg;
        pend_next       = 1'b0;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_base_next   = rsp_base_reg;
        rsp_units_next  = rsp_units_reg;

        unique case (state_reg) inside
            S_CLEAR:
            begin
                ptr_next = ptr_reg + IDX_W'(1);
                if (ptr_reg == LAST_IDX)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    bytes_next = req.request_bytes;
                    addr_next  = req.block_address;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                hint_next = gran_units;
                cnt_next  = '0;
                unit_next = '0;
                units_next = '0;
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (alloc_bad)
                    begin
                        res_status_next = ST_REJECT;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        units_next = CNT_W'(gran_units);
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
                else
                begin
                    if (free_bad)
                    begin
                        res_status_next = ST_REJECT;
                        state_next      = S_RESULT;
                    end
                    else
                    begin
                        unit_next  = addr_diff[GRANULE_SHIFT+IDX_W-1:GRANULE_SHIFT];
                        ptr_next   = addr_diff[GRANULE_SHIFT+IDX_W-1:GRANULE_SHIFT];
                        state_next = S_FREE_RD;
                    end
                end
            end
            S_SCAN:
            begin
                // issue one read a cycle, check the entry read last cycle
                pend_next = 1'b1;
                chk_next  = ptr_reg;
                ptr_next  = (ptr_reg == LAST_IDX) ? ptr_reg : (ptr_reg + IDX_W'(1));
                if (pend_reg)
                begin
                    cnt_next = run_cnt;
                    if (run_cnt == units_reg)
                    begin
                        unit_next  = fit_base[IDX_W-1:0];
                        ptr_next   = fit_base[IDX_W-1:0];
                        cnt_next   = '0;
                        state_next = S_MARK;
                    end
                    else if (chk_reg == LAST_IDX)
                    begin
                        units_next      = '0;
                        res_status_next = ST_NO_FIT;
                        state_next      = S_RESULT;
                    end
                end
            end
            S_MARK, S_RELEASE:
            begin
                ptr_next = ptr_reg + IDX_W'(1);
                cnt_next = cnt_inc;
                if (cnt_inc == units_reg)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_RESULT;
                end
            end
            S_FREE_RD:
            begin
                state_next = S_FREE_CHK;
            end
            S_FREE_CHK:
            begin
                cnt_next = '0;
                if (!entry_used)
                begin
                    unit_next       = '0;
                    res_status_next = ST_NOT_USED;
                    state_next      = S_RESULT;
                end
                else if (free_units > units_left)
                begin
                    unit_next       = '0;
                    res_status_next = ST_REJECT;
                    state_next      = S_RESULT;
                end
                else
                begin
                    units_next = CNT_W'(free_units);
                    state_next = S_RELEASE;
                end
            end
            S_RESULT:
            begin
                // failures leave base index and count at zero
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    if (res_status_reg == ST_OK)
                    begin
                        rsp_base_next  = cfg.pool_base
                                       + (ADDR_W'(unit_reg) << GRANULE_SHIFT);
                        rsp_units_next = sat_units(units_reg);
                    end
                    else
                    begin
                        rsp_base_next  = '0;
                        rsp_units_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cmd_reg        <= CMD_ALLOC;
            bytes_reg      <= '0;
            addr_reg       <= '0;
            units_reg      <= '0;
            hint_reg       <= '0;
            unit_reg       <= '0;
            ptr_reg        <= '0;
            chk_reg        <= '0;
            pend_reg       <= 1'b0;
            cnt_reg        <= '0;
            res_status_reg <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_status_reg <= ST_OK;
            rsp_base_reg   <= '0;
            rsp_units_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            bytes_reg      <= bytes_next;
            addr_reg       <= addr_next;
            units_reg      <= units_next;
            hint_reg       <= hint_next;
            unit_reg       <= unit_next;
            ptr_reg        <= ptr_next;
            chk_reg        <= chk_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
            res_status_reg <= res_status_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_status_reg <= rsp_status_next;
            rsp_base_reg   <= rsp_base_next;
            rsp_units_reg  <= rsp_units_next;
        end
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.block_base = rsp_base_reg;
    assign rsp.run_units  = rsp_units_reg;

endmodule

>>> hw/rtl/first_fit_unit_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_unit_allocator_top
// First-fit contiguous granule allocator with a per-granule table in RAM.
// ----------------------------------------------------------------------------
// An allocate runs through the check, the first-fit scan and the mark pass;
// a free through the check, the entry read and check and the release pass,
// and a rejected address ends at the check; one item in flight at a time.
// The scan reads one table entry a cycle through the single RAM read port.
// After reset a clearing pass zeroes the whole table; no items
// are taken during it, configuration writes are taken at all times.
module first_fit_unit_allocator_top import ffa_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    ffa_req_if.sink    req,
    ffa_rsp_if.source  rsp,
    ffa_cfg_if.sink    cfg
);

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [BYTES_W-1:0] max_request_reg;
    cfg_t               cfg_bus;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [IDX_W-1:0]   mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            max_request_reg <= MAX_REQUEST_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_POOL_BASE:   pool_base_reg   <= cfg.data;
                CFG_MAX_REQUEST: max_request_reg <= cfg.data[BYTES_W-1:0];
                default:         pool_base_reg   <= pool_base_reg;
            endcase
        end
    end

    assign cfg.ready = 1'b1;
    assign cfg_bus   = '{pool_base: pool_base_reg, max_request_bytes: max_request_reg};

    // granule table: used flag over run length
    ffa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (UNIT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // allocation sequencer
    ffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_bus),
        .req       (req),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

>>> bench/tb_first_fit_unit_allocator_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_unit_allocator_top
// Self-checking bench for the first-fit granule allocator. A driver feeds
// allocate and free items from a queue. A predictor keeps its own granule
// table and computes the answer of each accepted item. A monitor compares
// every result, field by field, against the oldest predicted answer. The
// run moves through several pool settings and through sender and receiver
// idle patterns, and holds the receiver off once so that the block stalls.
// ----------------------------------------------------------------------------
module tb_first_fit_unit_allocator_top;
    import ffa_pkg::*;

    localparam longint unsigned GRANULE_BYTES = 64'd1 << GRANULE_SHIFT;
    localparam int HOLD_CYCLES = 400;
    localparam int END_CYCLES  = 600;

    // how a free item picks its address when it is loaded
    typedef enum logic [1:0] {AIM_FIXED, AIM_RUN_HEAD, AIM_RUN_BODY} aim_t;

    typedef struct {
        logic               command;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
        aim_t               aim;
    } order_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   base;
        logic [UNITS_W-1:0]  units;
    } grant_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();
    ffa_cfg_if cfg_ch ();

    first_fit_unit_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predictor copy of the granule table and the registers
    bit                 unit_used [UNIT_COUNT];
    bit [LEN_W-1:0]     run_len   [UNIT_COUNT];
    logic [ADDR_W-1:0]  pool_base_q = '0;
    logic [BYTES_W-1:0] max_req_q   = MAX_REQUEST_RST;

    order_t order_q [$];
    grant_t grant_q [$];
    int     orders_made  = 0;
    int     items_taken  = 0;
    int     results_seen = 0;
    int     errors       = 0;
    int     gap_pct      = 0;
    int     stall_pct    = 0;
    int     hold_left    = 0;
    bit     held         = 1'b0;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // first-fit allocation of whole granules
    function automatic grant_t allocate_run(logic [BYTES_W-1:0] bytes);
        grant_t            g;
        longint unsigned   need;
        longint unsigned   first;
        int                j;
        bit                clash;
        g = '0;
        g.status = ST_REJECT;
        if (bytes == 0 || bytes > max_req_q)
            return g;
        need = (64'(bytes) + GRANULE_BYTES - 1) >> GRANULE_SHIFT;
        if (need == 0 || (need << GRANULE_SHIFT) > 64'(max_req_q) ||
            need > UNIT_COUNT || need > MAX_RUN)
            return g;
        first = 0;
        while (first + need <= UNIT_COUNT)
        begin
            clash = 1'b0;
            for (j = 0; j < need; j++)
            begin
                if (unit_used[first + j])
                begin
                    clash = 1'b1;
                    break;
                end
            end
            if (!clash)
            begin
                for (j = 0; j < need; j++)
                begin
                    unit_used[first + j] = 1'b1;
                    run_len[first + j]   = '0;
                end
                run_len[first] = LEN_W'(need);
                g.status = ST_OK;
                g.base   = ADDR_W'(64'(pool_base_q) + (first << GRANULE_SHIFT));
                g.units  = UNITS_W'(need);
                return g;
            end
            // resume past the used granule
            first = first + j + 1;
        end
        g.status = ST_NO_FIT;
        return g;
    endfunction

    // release of a run, by its recorded length or by the size hint
    function automatic grant_t release_run(logic [ADDR_W-1:0] addr, logic [BYTES_W-1:0] hint);
        grant_t          g;
        longint unsigned lo, hi, off, idx, cnt, k;
        g = '0;
        g.status = ST_REJECT;
        lo = 64'(pool_base_q);
        hi = lo + (64'(UNIT_COUNT) << GRANULE_SHIFT);
        if (64'(addr) < lo || 64'(addr) >= hi)
            return g;
        off = 64'(addr) - lo;
        if ((off & (GRANULE_BYTES - 1)) != 0)
            return g;
        idx = off >> GRANULE_SHIFT;
        if (!unit_used[idx])
        begin
            g.status = ST_NOT_USED;
            return g;
        end
        cnt = run_len[idx];
        if (cnt == 0)
        begin
            cnt = (64'(hint) + GRANULE_BYTES - 1) >> GRANULE_SHIFT;
            if (cnt == 0)
                cnt = 1;
        end
        if (idx + cnt > UNIT_COUNT)
            return g;
        for (k = 0; k < cnt; k++)
        begin
            unit_used[idx + k] = 1'b0;
            run_len[idx + k]   = '0;
        end
        g.status = ST_OK;
        g.base   = ADDR_W'(lo + (idx << GRANULE_SHIFT));
        g.units  = (cnt > 511) ? 9'h1FF : UNITS_W'(cnt);
        return g;
    endfunction

    // address of a random live run head or mid-run granule
    function automatic logic [ADDR_W-1:0] live_address(bit body);
        int picks [$];
        int pick;
        for (int k = 0; k < UNIT_COUNT; k++)
        begin
            if (unit_used[k] && ((run_len[k] == 0) == body))
                picks.push_back(k);
        end
        if (picks.size() == 0)
            pick = $urandom_range(UNIT_COUNT - 1);
        else
            pick = picks[$urandom_range(picks.size() - 1)];
        return ADDR_W'(64'(pool_base_q) + (64'(pick) << GRANULE_SHIFT));
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report(string what);
        errors++;
        if (errors <= 50)
            $display("ERROR %0t ns: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        order_t nxt;
        grant_t want;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            // predict the answer of the item taken at this edge
            if (req_ch.valid && req_ch.ready)
            begin
                if (req_ch.command == CMD_ALLOC)
                    want = allocate_run(req_ch.request_bytes);
                else
                    want = release_run(req_ch.block_address, req_ch.request_bytes);
                grant_q.push_back(want);
                items_taken++;
            end
            // offer the next item, or idle
            if (!req_ch.valid || req_ch.ready)
            begin
                if (order_q.size() != 0 && $urandom_range(99) >= gap_pct)
                begin
                    nxt = order_q.pop_front();
                    if (nxt.aim == AIM_RUN_HEAD)
                        nxt.addr = live_address(1'b0);
                    else if (nxt.aim == AIM_RUN_BODY)
                        nxt.addr = live_address(1'b1);
                    req_ch.valid         <= 1'b1;
                    req_ch.command       <= nxt.command;
                    req_ch.request_bytes <= nxt.bytes;
                    req_ch.block_address <= nxt.addr;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // result monitor and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen++;
                if (grant_q.size() == 0)
                begin
                    report("result with no item outstanding");
                end
                else
                begin
                    want = grant_q.pop_front();
                    if (rsp_ch.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         rsp_ch.status, want.status));
                    if (rsp_ch.block_base !== want.base)
                        report($sformatf("block_base %h, expected %h",
                                         rsp_ch.block_base, want.base));
                    if (rsp_ch.run_units !== want.units)
                        report($sformatf("run_units %0d, expected %0d",
                                         rsp_ch.run_units, want.units));
                end
            end
            // one long hold-off so the block backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!held && results_seen >= 60)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    task automatic push_order(logic cmd, logic [BYTES_W-1:0] bytes,
                              logic [ADDR_W-1:0] addr, aim_t aim);
        order_t o;
        o.command = cmd;
        o.bytes   = bytes;
        o.addr    = addr;
        o.aim     = aim;
        order_q.push_back(o);
        orders_made++;
    endtask

    // mostly small runs and frees of live runs, some malformed items
    task automatic add_random(int n);
        int                 sel;
        logic [BYTES_W-1:0] bytes;
        logic [ADDR_W-1:0]  addr;
        repeat (n)
        begin
            sel  = $urandom_range(99);
            addr = ADDR_W'({$urandom(), $urandom()});
            if (sel < 50)
            begin
                sel = $urandom_range(99);
                if (sel < 60)
                    bytes = $urandom_range(4 * GRANULE_BYTES, 1);
                else if (sel < 80)
                    bytes = $urandom_range(32 * GRANULE_BYTES, 1);
                else if (sel < 88)
                begin
                    case ($urandom_range(3))
                        0: bytes = max_req_q;
                        1: bytes = max_req_q + 1;
                        2: bytes = BYTES_W'(MAX_RUN) << GRANULE_SHIFT;
                        default: bytes = BYTES_W'(UNIT_COUNT) << GRANULE_SHIFT;
                    endcase
                end
                else if (sel < 93)
                    bytes = '0;
                else
                    bytes = $urandom();
                push_order(CMD_ALLOC, bytes, addr, AIM_FIXED);
            end
            else if (sel < 86)
            begin
                push_order(CMD_FREE, $urandom(), addr, AIM_RUN_HEAD);
            end
            else if (sel < 93)
            begin
                bytes = $urandom_range(1) ? '0 : $urandom_range(3 * GRANULE_BYTES);
                push_order(CMD_FREE, bytes, addr, AIM_RUN_BODY);
            end
            else if (sel < 96)
            begin
                addr = ADDR_W'(64'(pool_base_q) +
                               (64'($urandom_range(300)) << GRANULE_SHIFT));
                push_order(CMD_FREE, $urandom(), addr, AIM_FIXED);
            end
            else
            begin
                push_order(CMD_FREE, $urandom(), addr, AIM_FIXED);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (items_taken != orders_made || grant_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_POOL_BASE)
            pool_base_q = value;
        else
            max_req_q = value[BYTES_W-1:0];
    endtask

    // new pool setting once the block is idle, then random items
    task automatic next_phase(logic [CFG_DATA_W-1:0] base,
                              logic [CFG_DATA_W-1:0] limit, int n);
        wait_drained();
        write_reg(CFG_POOL_BASE, base);
        write_reg(CFG_MAX_REQUEST, limit);
        add_random(n);
    endtask

    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.command       = CMD_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.block_address = '0;
        rsp_ch.ready         = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_POOL_BASE;
        cfg_ch.data          = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, sender idles less than the receiver
        gap_pct   = 32;
        stall_pct = 54;
        push_order(CMD_ALLOC, 32'd0, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd1, '1, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd65536, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd65537, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd8388608, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd8388609, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'hFFFF_FFFF, '0, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h1_0000, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd1, '0, AIM_FIXED);
        // mid-run free with a zero hint releases one granule
        push_order(CMD_FREE, 32'd0, 48'h5_0000, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h5_0000, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h2_0001, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h100_0000, AIM_FIXED);
        // hints that run past the last granule
        push_order(CMD_FREE, 32'hFFFF_FFFF, 48'h6_0000, AIM_FIXED);
        push_order(CMD_FREE, 32'd251 << GRANULE_SHIFT, 48'h6_0000, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h4_0000, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd131072, '0, AIM_FIXED);
        // mid-run free spilling into the next run
        push_order(CMD_FREE, 32'd3 << GRANULE_SHIFT, 48'h3_0000, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h4_0000, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'h2_0000, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd8388608, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd8388608, '0, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd1, '0, AIM_FIXED);
        push_order(CMD_FREE, 32'd0, 48'hFFFF_FFFF_FFFF, AIM_FIXED);
        push_order(CMD_ALLOC, 32'd255 << GRANULE_SHIFT, '0, AIM_FIXED);
        add_random(200);

        // pool wrapping past the top of the address space, widest limit
        next_phase(48'hFFFF_FF80_0000, 48'hABCD_FFFF_FFFF, 250);

        // receiver idles less than the sender
        gap_pct   = 54;
        stall_pct = 32;
        next_phase(48'h1234_5678_9ABC, 48'h0, 40);
        next_phase(48'hFFFF_FFFF_FFFF, 48'h1, 60);

        // no idling
        gap_pct   = 0;
        stall_pct = 0;
        next_phase(48'h0, 48'd98304, 100);
        next_phase(48'h0000_0100_0000, 48'd16711680, 250);

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (grant_q.size() != 0)
            report($sformatf("%0d results never arrived", grant_q.size()));
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #20_000_000;
        $display("TIMEOUT after %0t ns", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
